// ===== rtl/fpiir_pkg.sv =====
`timescale 1ns / 1ps

package fpiir_pkg;

    // Filter shape: TAPS feedforward taps, TAPS-1 feedback taps (a0 is one)
    localparam int TAPS     = 7;
    localparam int HIST     = TAPS - 1;
    localparam int TAP_W    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int HIST_W   = (HIST > 1) ? $clog2(HIST) : 1;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int FRAC_W   = 4;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAC_BITS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FWD_COEF_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FWD_COEF_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_HIGH  = 3'd4;

    localparam logic [FRAC_W-1:0] FRAC_BITS_RESET = 4'd14;

    // Control from the sequencer to one MAC lane
    typedef struct packed {
        logic clear;   // zero the accumulator
        logic issue;   // register a new product
    } mac_ctrl_t;

    // Saturate a wide signed value to 16 bits
    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [PROD_W:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 33'sd32767)
            r = 16'sh7FFF;
        else if (v < -33'sd32768)
            r = 16'sh8000;
        else
            r = v[SAMPLE_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/fpiir_mac.sv =====
`timescale 1ns / 1ps

module fpiir_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fpiir_pkg::mac_ctrl_t                 ctrl,
    input  logic signed [fpiir_pkg::COEF_W-1:0]  coef,
    input  logic signed [fpiir_pkg::SAMPLE_W-1:0] data,
    input  logic [fpiir_pkg::FRAC_W-1:0]         frac_bits,
    output logic signed [fpiir_pkg::SAMPLE_W-1:0] acc
);
    import fpiir_pkg::*;

    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic                       prod_vld_reg;
    logic signed [SAMPLE_W-1:0] acc_reg;
    logic signed [SAMPLE_W-1:0] acc_next;
    logic signed [PROD_W:0]     rnd;
    logic signed [PROD_W:0]     rounded;
    logic signed [PROD_W:0]     shifted;
    logic signed [SAMPLE_W-1:0] term;
    logic signed [SAMPLE_W:0]   sum;

    assign prod_next = coef * data;

    // Round half up, floor shift, saturate, then saturating add
    always_comb
    begin
        if (frac_bits == '0)
            rnd = '0;
        else
            rnd = 33'sd1 <<< (frac_bits - 4'd1);
        rounded  = {prod_reg[PROD_W-1], prod_reg} + rnd;
        shifted  = rounded >>> frac_bits;
        term     = sat16(shifted);
        sum      = {acc_reg[SAMPLE_W-1], acc_reg} + {term[SAMPLE_W-1], term};
        acc_next = sat16({{(PROD_W-SAMPLE_W){sum[SAMPLE_W]}}, sum});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= ctrl.issue;
            if (ctrl.clear)
                acc_reg <= '0;
            else if (prod_vld_reg)
                acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
            prod_reg <= prod_next;
    end

    assign acc = acc_reg;

endmodule

// ===== rtl/fixed_point_iir_direct_form1_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   sample_in[15:0] signed, start_of_block
// output    out        out_valid / out_ready sample_out[15:0] signed
// config    in         cfg_we (no wait)      cfg_index[2:0], cfg_data[63:0]
//
// After acceptance, two MAC lanes step one tap per cycle in RUN, DRAIN lets
// the product register drain into the accumulators, and DONE forms the output
// difference and stores it in the result register. The sequencer then returns
// to idle before it accepts the next request.
// in_ready is high only while idle; a held result does not stop the next
// request from being accepted, but the next result waits for out_ready.
// Reset clears the histories, the sequencer and the coefficient registers, and sets frac_bits to 14.
module fixed_point_iir_direct_form1_top (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic signed [fpiir_pkg::SAMPLE_W-1:0]    sample_in,
    input  logic                                     start_of_block,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [fpiir_pkg::SAMPLE_W-1:0]    sample_out,
    input  logic                                     cfg_we,
    input  logic [fpiir_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [fpiir_pkg::CFG_W-1:0]              cfg_data
);
    import fpiir_pkg::*;

    // Sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [TAP_W-1:0]           step_reg;
    logic [TAP_W-1:0]           step_next;

    // Configuration registers
    logic [FRAC_W-1:0]          frac_bits_reg;
    logic [CFG_W-1:0]           fwd_low_reg;
    logic [CFG_W-1:0]           fwd_high_reg;
    logic [CFG_W-1:0]           fb_low_reg;
    logic [CFG_W-1:0]           fb_high_reg;

    // Histories: entry 0 is the most recent past sample
    logic signed [SAMPLE_W-1:0] hist_x_reg [HIST];
    logic signed [SAMPLE_W-1:0] hist_y_reg [HIST];
    logic signed [SAMPLE_W-1:0] x_reg;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_reg;

    logic                       accept;
    logic                       finish;
    logic [HIST_W-1:0]          hidx;
    logic [2*CFG_W-1:0]         fwd_all;
    logic [2*CFG_W-1:0]         fb_all;
    logic signed [COEF_W-1:0]   fwd_coef;
    logic signed [COEF_W-1:0]   fb_coef;
    logic signed [SAMPLE_W-1:0] fwd_data;
    logic signed [SAMPLE_W-1:0] fb_data;
    mac_ctrl_t                  fwd_ctrl;
    mac_ctrl_t                  fb_ctrl;
    logic signed [SAMPLE_W-1:0] acc_b;
    logic signed [SAMPLE_W-1:0] acc_a;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [SAMPLE_W-1:0] y;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign finish   = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_bits_reg <= FRAC_BITS_RESET;
            fwd_low_reg   <= '0;
            fwd_high_reg  <= '0;
            fb_low_reg    <= '0;
            fb_high_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAC_BITS:     frac_bits_reg <= cfg_data[FRAC_W-1:0];
                REG_FWD_COEF_LOW:  fwd_low_reg   <= cfg_data;
                REG_FWD_COEF_HIGH: fwd_high_reg  <= cfg_data;
                REG_FB_COEF_LOW:   fb_low_reg    <= cfg_data;
                REG_FB_COEF_HIGH:  fb_high_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: one tap per cycle in RUN, then drain and form the result
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RUN;
                    step_next  = '0;
                end
            end
            S_RUN:
            begin
                if (step_reg == TAP_W'(TAPS - 1))
                    state_next = S_DRAIN;
                else
                    step_next = step_reg + 1'b1;
            end
            S_DRAIN:
                state_next = S_DONE;
            S_DONE:
            begin
                if (finish)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Tap operands: feedforward tap 0 uses the new sample, feedback starts at a1
    assign fwd_all  = {fwd_high_reg, fwd_low_reg};
    assign fb_all   = {fb_high_reg, fb_low_reg};
    assign hidx     = (step_reg == '0) ? '0 : HIST_W'(step_reg - 1'b1);
    assign fwd_coef = fwd_all[{step_reg, 4'b0000} +: COEF_W];
    assign fb_coef  = fb_all[{hidx, 4'b0000} +: COEF_W];
    assign fwd_data = (step_reg == '0) ? x_reg : hist_x_reg[hidx];
    assign fb_data  = hist_y_reg[hidx];

    assign fwd_ctrl.clear = accept;
    assign fwd_ctrl.issue = (state_reg == S_RUN);
    assign fb_ctrl.clear  = accept;
    assign fb_ctrl.issue  = (state_reg == S_RUN) && (step_reg != '0);

    fpiir_mac u_fwd_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (fwd_ctrl),
        .coef      (fwd_coef),
        .data      (fwd_data),
        .frac_bits (frac_bits_reg),
        .acc       (acc_b)
    );

    fpiir_mac u_fb_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (fb_ctrl),
        .coef      (fb_coef),
        .data      (fb_data),
        .frac_bits (frac_bits_reg),
        .acc       (acc_a)
    );

    // Output: saturated difference of the two accumulators, taken wide
    assign diff = {acc_b[SAMPLE_W-1], acc_b} - {acc_a[SAMPLE_W-1], acc_a};
    assign y    = sat16({{(PROD_W-SAMPLE_W){diff[SAMPLE_W]}}, diff});

    always_ff @(posedge clk)
    begin
        if (accept)
            x_reg <= sample_in;
        if (finish)
            out_reg <= y;
    end

    // Histories: clear on a block start, advance when the result is stored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST; i++)
            begin
                hist_x_reg[i] <= '0;
                hist_y_reg[i] <= '0;
            end
        end
        else if (accept && start_of_block)
        begin
            for (int i = 0; i < HIST; i++)
            begin
                hist_x_reg[i] <= '0;
                hist_y_reg[i] <= '0;
            end
        end
        else if (finish)
        begin
            for (int i = HIST - 1; i > 0; i--)
            begin
                hist_x_reg[i] <= hist_x_reg[i-1];
                hist_y_reg[i] <= hist_y_reg[i-1];
            end
            hist_x_reg[0] <= x_reg;
            hist_y_reg[0] <= y;
        end
    end

    // Result register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_reg;

`ifndef SYNTHESIS
    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_RUN && step_reg == '0))
        else $error("accepted request did not start the tap sweep");

    a_drain_after_last_tap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> ($past(step_reg) == TAP_W'(TAPS - 1)))
        else $error("drain entered before the last tap");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == S_DONE))
        else $error("result shown without a finished request");
`endif

endmodule
